// ===== sv/ksm_pkg.sv =====
`timescale 1ns / 1ps
package ksm_pkg;

  localparam int KEY_W        = 8;
  localparam int SEQ_W        = 64;
  localparam int NUM_SEQ_REGS = 6;
  localparam int CFG_IDX_W    = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LEFT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_RIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_TURN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_DROP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_QUIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_PAUSE = 3'd5;

  typedef logic [SEQ_W-1:0] seq_word_t;
  typedef logic [NUM_SEQ_REGS-1:0][SEQ_W-1:0] seq_bank_t;

  typedef struct packed {
    logic [KEY_W-1:0] key_byte;
    logic             byte_present;
    logic             read_failed;
  } in_t;

  typedef struct packed {
    logic [NUM_SEQ_REGS-1:0] fired_mask;
    logic                    waiting;
  } out_t;

endpackage

// ===== sv/key_sequence_matcher.sv =====
`timescale 1ns / 1ps
// channel  signals                         transfer when
// in       in_valid, in_ready, in_data     in_valid && in_ready
// out      out_valid, out_ready, out_data  out_valid && out_ready
// cfg      cfg_we, cfg_idx, cfg_wdata      cfg_we
//
// One poll a cycle while the result is not stalled, through an input
// register, then the compare against all sequences and the buffer update
// in one step into the result register.
// Reset empties the key buffer and clears every sequence.
// A stalled result holds; the input register still takes one more poll.
module key_sequence_matcher #(
  parameter int MAX_KEY_LEN  = 8,
  parameter int NUM_BINDINGS = 6
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ksm_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ksm_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [ksm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  ksm_pkg::seq_word_t            cfg_wdata
);
  import ksm_pkg::*;

  seq_bank_t seqs;
  in_t       s1_data_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  out_t      out_data_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  out_t      result;
  logic      advance;

  ksm_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .seqs      (seqs)
  );

  ksm_match_core #(
    .MAX_KEY_LEN  (MAX_KEY_LEN),
    .NUM_BINDINGS (NUM_BINDINGS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (s1_data_r),
    .seqs    (seqs),
    .result  (result)
  );

  assign advance  = s1_valid_r && (out_ready || !out_valid_r);
  assign in_ready = !s1_valid_r || advance;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ready) begin
      s1_valid_nxt = in_valid;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid_r)
    else $error("result valid after reset");

  a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input blocked with empty result register");

  a_fail_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s1_data_r.read_failed) |=> (out_data_r.fired_mask == '0))
    else $error("failed read fired a sequence");

  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced poll lost");

endmodule

// ===== sv/ksm_cfg_regs.sv =====
`timescale 1ns / 1ps
module ksm_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [ksm_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  ksm_pkg::seq_word_t           cfg_wdata,
  output ksm_pkg::seq_bank_t           seqs
);
  import ksm_pkg::*;

  seq_bank_t seq_r;
  seq_bank_t seq_nxt;

  always_comb begin
    seq_nxt = seq_r;
    if (cfg_we) begin
      case (cfg_idx)
        REG_SEQ_LEFT:  seq_nxt[0] = cfg_wdata;
        REG_SEQ_RIGHT: seq_nxt[1] = cfg_wdata;
        REG_SEQ_TURN:  seq_nxt[2] = cfg_wdata;
        REG_SEQ_DROP:  seq_nxt[3] = cfg_wdata;
        REG_SEQ_QUIT:  seq_nxt[4] = cfg_wdata;
        REG_SEQ_PAUSE: seq_nxt[5] = cfg_wdata;
        default: seq_nxt = seq_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
    end else begin
      seq_r <= seq_nxt;
    end
  end

  assign seqs = seq_r;

endmodule

// ===== sv/ksm_match_core.sv =====
`timescale 1ns / 1ps
module ksm_match_core #(
  parameter int MAX_KEY_LEN  = 8,
  parameter int NUM_BINDINGS = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  ksm_pkg::in_t       item,
  input  ksm_pkg::seq_bank_t seqs,
  output ksm_pkg::out_t      result
);
  import ksm_pkg::*;

  localparam int LEN_W      = $clog2(MAX_KEY_LEN + 1);
  localparam int NUM_ACTIVE = (NUM_BINDINGS < NUM_SEQ_REGS) ? NUM_BINDINGS : NUM_SEQ_REGS;

  logic [MAX_KEY_LEN-1:0][KEY_W-1:0] buf_r;
  logic [MAX_KEY_LEN-1:0][KEY_W-1:0] buf_nxt;
  logic [LEN_W-1:0]                  len_r;
  logic [LEN_W-1:0]                  len_nxt;

  logic [LEN_W-1:0]        app_len;
  logic                    overflow;
  logic                    prefix;
  logic                    exact;
  logic                    keep;
  logic [NUM_SEQ_REGS-1:0] mask;

  always_comb begin
    buf_nxt  = buf_r;
    app_len  = len_r;
    overflow = 1'b0;
    if (item.byte_present && (item.key_byte != '0)) begin
      if (len_r < LEN_W'(MAX_KEY_LEN)) begin
        for (int i = 0; i < MAX_KEY_LEN; i++) begin
          if (len_r == LEN_W'(i)) begin
            buf_nxt[i] = item.key_byte;
          end
        end
        app_len = LEN_W'(len_r + 1'b1);
      end else begin
        overflow = 1'b1;
      end
    end

    mask = '0;
    keep = 1'b0;
    for (int k = 0; k < NUM_ACTIVE; k++) begin
      prefix = 1'b1;
      exact  = (app_len == LEN_W'(MAX_KEY_LEN));
      for (int i = 0; i < MAX_KEY_LEN; i++) begin
        if ((LEN_W'(i) < app_len) && (seqs[k][KEY_W*i +: KEY_W] != buf_nxt[i])) begin
          prefix = 1'b0;
        end
        if ((app_len == LEN_W'(i)) && (seqs[k][KEY_W*i +: KEY_W] == '0)) begin
          exact = 1'b1;
        end
      end
      if (prefix) begin
        if (exact) begin
          mask[k] = 1'b1;
        end else begin
          keep = 1'b1;
        end
      end
    end
    if (overflow || (app_len == '0)) begin
      mask = '0;
      keep = 1'b0;
    end

    if (item.read_failed) begin
      result.fired_mask = '0;
      result.waiting    = (len_r != '0);
      len_nxt           = len_r;
      buf_nxt           = buf_r;
    end else begin
      result.fired_mask = mask;
      result.waiting    = keep;
      len_nxt           = keep ? app_len : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (advance) begin
      len_r <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      buf_r <= buf_nxt;
    end
  end

endmodule
